// ===== rtl/bhpq_pkg.sv =====
// Package for the binary heap priority queue: sizes, operation and status codes,
// controller command and datapath status structures, and the key compare.
// Depends on nothing.
package bhpq_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    ACT_INSERT      = 2'd0,
    ACT_REMOVE_LAST = 2'd1,
    ACT_REMOVE_KEY  = 2'd2,
    ACT_NOP         = 2'd3
  } bhpq_action_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } bhpq_status_e;

  typedef struct packed {
    logic accept;
    logic up_rd;
    logic up_cmp;
    logic dn_load;
    logic dn_get;
    logic dn_rdl;
    logic dn_rdr;
    logic dn_cmp;
    logic scan;
    logic rm_last;
    logic rm_get;
    logic fin;
  } bhpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_root;
    logic up_move;
    logic mode_rm;
    logic l_valid;
    logic dn_move;
    logic match;
    logic scan_end;
    logic pos_is_last;
    logic out_free;
  } bhpq_stat_t;

  function automatic logic outranks(input logic is_min,
                                    input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
    return is_min ? (a < b) : (a > b);
  endfunction

endpackage

// ===== rtl/binary_heap_priority_queue_core.sv =====
// Binary heap priority queue of 128 signed 32-bit keys, max or min order.
// Input stream: s_axis_tuser carries the operation (insert, remove last, remove by
// key) and s_axis_tdata the key. Output stream: one result per operation with
// status, entry count, root valid flag and root key.
// A single configuration bit, written through cfg_we_i, selects min order.
// Remove last and no-op go from the input transfer straight to the result. Insert
// climbs one level per parent read and compare and writes the key where it stops.
// Remove by key scans one entry per cycle; a found key is replaced by the last
// entry, which climbs and then descends, while a missing key ends the scan with
// not found status. The search loop issues one read of the key memory per cycle.
// One operation is in flight at a time; the next input transfer is taken as soon
// as the result register is free or being read in that cycle.
// If the receiver stalls, the result waits in the output register and no new
// operation is taken. Reset empties the heap and selects max order; the key
// memory itself is not cleared, since only entries below the count are read.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_datapath.
module binary_heap_priority_queue_core import bhpq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] key_value.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] action.
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [9:2] entry_count, [10] top_valid, [42:11] top_value, rest zero.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i
);

  bhpq_cmd_t  cmd;
  bhpq_stat_t stat;

  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bhpq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_action_i (s_axis_tuser),
    .in_key_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/bhpq_ctrl.sv =====
// Controller state machine of the binary heap priority queue.
// Depends on bhpq_pkg; drives commands to and reads status from bhpq_datapath.
module bhpq_ctrl import bhpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_action_i,
  output logic               in_ready_o,
  input  bhpq_stat_t         stat_i,
  output bhpq_cmd_t          cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_UP_RD   = 12'b000000000010,
    S_UP_CMP  = 12'b000000000100,
    S_DN_LOAD = 12'b000000001000,
    S_DN_GET  = 12'b000000010000,
    S_DN_RDL  = 12'b000000100000,
    S_DN_RDR  = 12'b000001000000,
    S_DN_CMP  = 12'b000010000000,
    S_SCAN    = 12'b000100000000,
    S_RM_LAST = 12'b001000000000,
    S_RM_GET  = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_e;

  state_e       state_q, state_d;
  bhpq_action_e act;
  logic         accept;
  state_e       after_up;

  assign act        = bhpq_action_e'(in_action_i);
  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign after_up   = stat_i.mode_rm ? S_DN_LOAD : S_FIN;

  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.up_rd   = (state_q == S_UP_RD);
    cmd_o.up_cmp  = (state_q == S_UP_CMP);
    cmd_o.dn_load = (state_q == S_DN_LOAD);
    cmd_o.dn_get  = (state_q == S_DN_GET);
    cmd_o.dn_rdl  = (state_q == S_DN_RDL);
    cmd_o.dn_rdr  = (state_q == S_DN_RDR);
    cmd_o.dn_cmp  = (state_q == S_DN_CMP);
    cmd_o.scan    = (state_q == S_SCAN);
    cmd_o.rm_last = (state_q == S_RM_LAST);
    cmd_o.rm_get  = (state_q == S_RM_GET);
    cmd_o.fin     = (state_q == S_FIN);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (act == ACT_INSERT && !stat_i.full) begin
            state_d = S_UP_RD;
          end else if (act == ACT_REMOVE_KEY && !stat_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_UP_RD:   state_d = stat_i.idx_root ? after_up : S_UP_CMP;
      S_UP_CMP:  state_d = stat_i.up_move ? S_UP_RD : after_up;
      S_DN_LOAD: state_d = S_DN_GET;
      S_DN_GET:  state_d = S_DN_RDL;
      S_DN_RDL:  state_d = stat_i.l_valid ? S_DN_RDR : S_FIN;
      S_DN_RDR:  state_d = S_DN_CMP;
      S_DN_CMP:  state_d = stat_i.dn_move ? S_DN_RDL : S_FIN;
      S_SCAN: begin
        priority if (stat_i.match) begin
          state_d = S_RM_LAST;
        end else if (stat_i.scan_end) begin
          state_d = S_FIN;
        end
      end
      S_RM_LAST: state_d = S_RM_GET;
      S_RM_GET:  state_d = stat_i.pos_is_last ? S_FIN : S_UP_RD;
      S_FIN:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bhpq_datapath.sv =====
// Datapath of the binary heap priority queue: key memory, count, work registers,
// order register and the result register. Depends on bhpq_pkg.
module bhpq_datapath import bhpq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bhpq_cmd_t              cmd_i,
  output bhpq_stat_t             stat_o,
  input  logic [1:0]             in_action_i,
  input  logic [KEY_W-1:0]       in_key_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [KEY_W-1:0] mem [CAPACITY];

  logic [KEY_W-1:0]       rd_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [KEY_W-1:0]       val_q, val_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic [KEY_W-1:0]       lt_q, lt_d;
  logic [KEY_W-1:0]       root_q;
  logic [1:0]             status_q, status_d;
  logic                   mode_rm_q, mode_rm_d;
  logic                   order_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [KEY_W-1:0]       wr_data;

  bhpq_action_e           act;
  logic                   full, empty;
  logic [IDX_W-1:0]       idx_m1, parent;
  logic [CNT_W-1:0]       cnt_m1;
  logic [CHILD_W-1:0]     l_w, r_w, cnt_w;
  logic                   l_valid, r_valid;
  logic                   sel_l, sel_r, up_move;
  logic [KEY_W-1:0]       best_v;
  logic                   match, scan_end, pos_is_last;
  logic [KEY_W-1:0]       top_value;

  assign act         = bhpq_action_e'(in_action_i);
  assign full        = (cnt_q == CNT_W'(CAPACITY));
  assign empty       = (cnt_q == '0);
  assign idx_m1      = idx_q - 1'b1;
  assign parent      = {1'b0, idx_m1[IDX_W-1:1]};
  assign cnt_m1      = cnt_q - 1'b1;
  assign l_w         = {1'b0, idx_q, 1'b1};
  assign r_w         = l_w + 1'b1;
  assign cnt_w       = CHILD_W'(cnt_q);
  assign l_valid     = (l_w < cnt_w);
  assign r_valid     = (r_w < cnt_w);
  assign up_move     = outranks(order_q, val_q, rd_q);
  assign sel_l       = outranks(order_q, lt_q, val_q);
  assign best_v      = sel_l ? lt_q : val_q;
  assign sel_r       = r_valid && outranks(order_q, rd_q, best_v);
  assign match       = cmp_vld_q && (rd_q == key_q);
  assign scan_end    = !cmp_vld_q && (scan_q >= cnt_q);
  assign pos_is_last = (CNT_W'(pos_q) == cnt_q);
  assign top_value   = empty ? '0 : root_q;

  always_comb begin
    stat_o             = '0;
    stat_o.full        = full;
    stat_o.empty       = empty;
    stat_o.idx_root    = (idx_q == '0);
    stat_o.up_move     = up_move;
    stat_o.mode_rm     = mode_rm_q;
    stat_o.l_valid     = l_valid;
    stat_o.dn_move     = sel_l || sel_r;
    stat_o.match       = match;
    stat_o.scan_end    = scan_end;
    stat_o.pos_is_last = pos_is_last;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    val_d     = val_q;
    key_d     = key_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    lt_d      = lt_q;
    status_d  = status_q;
    mode_rm_d = mode_rm_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = val_q;
    rd_en     = 1'b0;
    rd_addr   = '0;

    if (cmd_i.accept) begin
      key_d     = in_key_i;
      scan_d    = '0;
      cmp_vld_d = 1'b0;
      status_d  = STS_DONE;
      mode_rm_d = (act == ACT_REMOVE_KEY);
      unique case (act)
        ACT_INSERT: begin
          if (full) begin
            status_d = STS_FULL;
          end else begin
            val_d = in_key_i;
            idx_d = cnt_q[IDX_W-1:0];
            cnt_d = cnt_q + 1'b1;
          end
        end
        ACT_REMOVE_LAST: begin
          if (empty) begin
            status_d = STS_EMPTY;
          end else begin
            cnt_d = cnt_m1;
          end
        end
        ACT_REMOVE_KEY: begin
          if (empty) begin
            status_d = STS_EMPTY;
          end
        end
        ACT_NOP: begin
          status_d = STS_DONE;
        end
        default: status_d = STS_DONE;
      endcase
    end

    if (cmd_i.up_rd) begin
      if (idx_q == '0) begin
        wr_en = 1'b1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
    end

    if (cmd_i.up_cmp) begin
      wr_en = 1'b1;
      if (up_move) begin
        wr_data = rd_q;
        idx_d   = parent;
      end
    end

    if (cmd_i.dn_load) begin
      rd_en   = 1'b1;
      rd_addr = pos_q;
      idx_d   = pos_q;
    end

    if (cmd_i.dn_get) begin
      val_d = rd_q;
    end

    if (cmd_i.dn_rdl) begin
      if (l_valid) begin
        rd_en   = 1'b1;
        rd_addr = l_w[IDX_W-1:0];
      end else begin
        wr_en = 1'b1;
      end
    end

    if (cmd_i.dn_rdr) begin
      lt_d = rd_q;
      if (r_valid) begin
        rd_en   = 1'b1;
        rd_addr = r_w[IDX_W-1:0];
      end
    end

    if (cmd_i.dn_cmp) begin
      wr_en = 1'b1;
      if (sel_r) begin
        wr_data = rd_q;
        idx_d   = r_w[IDX_W-1:0];
      end else if (sel_l) begin
        wr_data = lt_q;
        idx_d   = l_w[IDX_W-1:0];
      end
    end

    if (cmd_i.scan) begin
      if (scan_q < cnt_q) begin
        rd_en     = 1'b1;
        rd_addr   = scan_q[IDX_W-1:0];
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_q[IDX_W-1:0];
        scan_d    = scan_q + 1'b1;
      end else begin
        cmp_vld_d = 1'b0;
      end
      if (match) begin
        pos_d = cmp_idx_q;
      end else if (scan_end) begin
        status_d = STS_NOT_FOUND;
      end
    end

    if (cmd_i.rm_last) begin
      rd_en   = 1'b1;
      rd_addr = cnt_m1[IDX_W-1:0];
      cnt_d   = cnt_m1;
    end

    if (cmd_i.rm_get) begin
      val_d = rd_q;
      idx_d = pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    val_q     <= val_d;
    key_q     <= key_d;
    pos_q     <= pos_d;
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    lt_q      <= lt_d;
    status_q  <= status_d;
    mode_rm_q <= mode_rm_d;
    if (wr_en && wr_addr == '0) begin
      root_q <= wr_data;
    end
    if (cmd_i.fin) begin
      out_data_q <= {5'b0, top_value, !empty, 8'(cnt_q), status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      order_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
